// ===== hdl/iss_pkg.sv =====
// Shared types and constants of the identifier set store.
// Used by iss_ctrl, iss_dpath and id_set_store; depends on nothing.
`default_nettype none
package iss_pkg;

	localparam int KindW = 2;
	localparam int IdentW = 32;
	localparam int PosW = 4;
	localparam int CountW = 5;
	localparam int DefCapacity = 16;

	localparam logic [KindW-1:0] KIND_ADD = 2'd0;
	localparam logic [KindW-1:0] KIND_DEL = 2'd1;
	localparam logic [KindW-1:0] KIND_GET = 2'd2;

	localparam logic [IdentW-1:0] NONE_ID = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_SHIFT,
		ST_APPEND,
		ST_REMOVE,
		ST_GET_RD,
		ST_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch request word, rewind sweep to entry 0
		logic start_next;  // rewind sweep to the entry after the hit
		logic run;         // sweep reads one entry per cycle
		logic shift_wr;    // write swept entry one place down
		logic append;      // store ident at the tail, count up
		logic dec;         // count down
		logic get_rd;      // read entry at position
		logic result_load; // load the result register
		logic result_err;
		logic result_data; // result carries the read entry
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [KindW-1:0] kind;
		logic reserved;
		logic get_ok;
		logic full;
		logic hit;
		logic sweep_idle;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/iss_ctrl.sv =====
// Request sequencer of the identifier set store.
// Depends on iss_pkg; drives iss_dpath through cmd_t and reads sts_t.
`default_nettype none
module iss_ctrl import iss_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	state_t state_q, state_d;
	logic   err_q, err_d;
	logic   data_q, data_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			err_q       <= 1'b0;
			data_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			data_q  <= data_d;
			if (cmd.result_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		data_d  = data_q;
		cmd     = '0;
		cmd.result_err  = err_q;
		cmd.result_data = data_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				err_d  = 1'b1;
				data_d = 1'b0;
				state_d = ST_RESULT;
				case (sts.kind)
					KIND_ADD, KIND_DEL: begin
						if (!sts.reserved)
							state_d = ST_SCAN;
					end
					KIND_GET: begin
						if (sts.get_ok) begin
							err_d   = 1'b0;
							data_d  = 1'b1;
							state_d = ST_GET_RD;
						end
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				cmd.run = 1'b1;
				if (sts.hit) begin
					if (sts.kind == KIND_DEL) begin
						cmd.start_next = 1'b1;
						state_d        = ST_SHIFT;
					end else begin
						err_d   = 1'b0;
						state_d = ST_RESULT;
					end
				end else if (sts.sweep_idle) begin
					if (sts.kind == KIND_ADD && !sts.full) begin
						state_d = ST_APPEND;
					end else begin
						err_d   = 1'b1;
						state_d = ST_RESULT;
					end
				end
			end
			ST_SHIFT: begin
				cmd.run      = 1'b1;
				cmd.shift_wr = 1'b1;
				if (sts.sweep_idle)
					state_d = ST_REMOVE;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				err_d      = 1'b0;
				state_d    = ST_RESULT;
			end
			ST_REMOVE: begin
				cmd.dec = 1'b1;
				err_d   = 1'b0;
				state_d = ST_RESULT;
			end
			ST_GET_RD: begin
				cmd.get_rd = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result register is never overwritten while its word waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten while pending");

	// one request in flight: a new word is only taken once the last result is loaded
	a_accept_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after result");

	// a waiting result word stays valid until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result word dropped before accept");

endmodule
`default_nettype wire

// ===== hdl/iss_dpath.sv =====
// Datapath of the identifier set store: entry memory, count, sweep pipeline
// and result register. Depends on iss_pkg; commanded by iss_ctrl.
`default_nettype none
module iss_dpath import iss_pkg::*; #(
	parameter int CAPACITY = DefCapacity
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output sts_t                          sts,
	input  wire logic [KindW-1:0]         kind,
	input  wire logic signed [IdentW-1:0] ident,
	input  wire logic [PosW-1:0]          position,
	output logic                          status,
	output logic signed [IdentW-1:0]      ident_out,
	output logic [CountW-1:0]             count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > PosW) ? CW : PosW;

	logic [IdentW-1:0] mem [CAPACITY];

	logic [KindW-1:0]  kind_q;
	logic [IdentW-1:0] ident_q;
	logic [PosW-1:0]   pos_q;
	logic [CW-1:0]     held_q;
	logic [CW-1:0]     ridx_q;
	logic              rvalid_s1;
	logic [CW-1:0]     ridx_s1;
	logic [IdentW-1:0] rdata_s1;

	logic              issue;
	logic              rd_en;
	logic [AW-1:0]     raddr;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     held_x;
	logic              wr_en;
	logic [AW-1:0]     waddr;
	logic [IdentW-1:0] wdata;
	logic [CW-1:0]     shift_dst;

	assign pos_x  = XW'(pos_q);
	assign held_x = XW'(held_q);
	assign issue  = cmd.run && (ridx_q < held_q);
	assign rd_en  = issue || cmd.get_rd;
	assign raddr  = cmd.get_rd ? pos_x[AW-1:0] : ridx_q[AW-1:0];

	assign shift_dst = ridx_s1 - CW'(1);
	assign wr_en = cmd.append || (cmd.shift_wr && rvalid_s1);
	assign waddr = cmd.append ? held_q[AW-1:0] : shift_dst[AW-1:0];
	assign wdata = cmd.append ? ident_q : rdata_s1;

	assign sts.kind       = kind_q;
	assign sts.reserved   = (ident_q == NONE_ID);
	assign sts.get_ok     = (pos_x < held_x);
	assign sts.full       = (held_q >= CW'(CAPACITY));
	assign sts.hit        = rvalid_s1 && (rdata_s1 == ident_q);
	assign sts.sweep_idle = (ridx_q >= held_q) && !rvalid_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= wdata;
		if (rd_en)
			rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			ident_q <= ident;
			pos_q   <= position;
		end
		if (issue)
			ridx_s1 <= ridx_q;
		if (cmd.result_load) begin
			status    <= cmd.result_err;
			ident_out <= cmd.result_data ? rdata_s1 : NONE_ID;
			count     <= CountW'(held_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			ridx_q    <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd.append)
				held_q <= held_q + CW'(1);
			else if (cmd.dec)
				held_q <= held_q - CW'(1);
			// a rewind drops the word in flight
			if (cmd.capture) begin
				ridx_q    <= '0;
				rvalid_s1 <= 1'b0;
			end else if (cmd.start_next) begin
				ridx_q    <= ridx_s1 + CW'(1);
				rvalid_s1 <= 1'b0;
			end else begin
				if (issue)
					ridx_q <= ridx_q + CW'(1);
				rvalid_s1 <= issue;
			end
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("count beyond capacity");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (held_q < CW'(CAPACITY)) && !sts.reserved)
		else $error("append into full store or of reserved ident");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec |-> (held_q != '0))
		else $error("remove from empty store");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_wr && rvalid_s1) |-> (ridx_s1 != '0) && (ridx_s1 < held_q))
		else $error("shift write outside held entries");

endmodule
`default_nettype wire

// ===== hdl/id_set_store.sv =====
// Top level of the identifier set store: joins sequencer and datapath.
// Depends on iss_pkg, iss_ctrl and iss_dpath.
//
// Holds up to CAPACITY distinct 32-bit identifiers packed at the front of an
// entry memory, plus a count. kind selects add, delete or get; -1 is the
// reserved empty identifier and is refused. One request is worked at a time;
// in_ready is high only between requests, and the result word sits in an
// output register until taken. The memory has a single read port, so the
// search reads one entry per cycle. An add of an entry already held stops at
// its hit, any other add appends after the sweep if there is room, and a
// delete shifts the entries after its hit one place down. A delete miss, an
// add into a full store, a refused request or a failed get returns an error.
// No clearing pass: entries past the count are never read.
`default_nettype none
module id_set_store import iss_pkg::*; #(
	parameter int CAPACITY = DefCapacity
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [KindW-1:0]         kind,
	input  wire logic signed [IdentW-1:0] ident,
	input  wire logic [PosW-1:0]          position,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          status,
	output logic signed [IdentW-1:0]      ident_out,
	output logic [CountW-1:0]             count
);

	cmd_t cmd;
	sts_t sts;

	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	iss_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.ident     (ident),
		.position  (position),
		.status    (status),
		.ident_out (ident_out),
		.count     (count)
	);

endmodule
`default_nettype wire
